[hw/rtl/ffca_pkg.sv]
// ----------------------------------------------------------------------------
// ffca_pkg: shared types and constants of the first-fit allocator
// Command and status codes, configuration register indexes and the command
// and response structs between the controller and the header datapath.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int DEF_ARENA_MAX_UNITS = 4096;
    localparam int DEF_UNIT_BYTES      = 16;

    // Widest header address and link over the parameter range.
    localparam int MAX_AW = 16;
    localparam int MAX_LW = MAX_AW + 1;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;

    localparam logic CFG_ARENA_BASE  = 1'b0;
    localparam logic CFG_ARENA_UNITS = 1'b1;

    typedef struct packed {
        logic [MAX_AW-1:0] raddr;
        logic [MAX_AW-1:0] waddr;
        logic              we_free;
        logic              we_units;
        logic              we_next;
        logic              we_prev;
        logic              free;
        logic [MAX_LW-1:0] units;
        logic [MAX_LW-1:0] next;
        logic [MAX_LW-1:0] prev;
    } t_mem_cmd;

    typedef struct packed {
        logic              free;
        logic [MAX_LW-1:0] units;
        logic [MAX_LW-1:0] next;
        logic [MAX_LW-1:0] prev;
    } t_mem_rsp;

endpackage

[hw/rtl/ffca_ram.sv]
// ----------------------------------------------------------------------------
// ffca_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/ffca_datapath.sv]
// ----------------------------------------------------------------------------
// ffca_datapath: block header store
// Holds the free bit, length and free-list links of every block and folds
// any link at or beyond the arena limit to the null link on read.
// ----------------------------------------------------------------------------
module ffca_datapath
    import ffca_pkg::*;
#(
    parameter int ARENA_MAX_UNITS = DEF_ARENA_MAX_UNITS
) (
    input  logic     i_clk,
    input  t_mem_cmd i_cmd,
    output t_mem_rsp o_rsp
);

    localparam int AW = $clog2(ARENA_MAX_UNITS);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(ARENA_MAX_UNITS);

    logic          rd_free;
    logic [LW-1:0] rd_units;
    logic [LW-1:0] rd_next;
    logic [LW-1:0] rd_prev;

    ffca_ram #(.WIDTH(1), .DEPTH(ARENA_MAX_UNITS)) u_free (
        .i_clk(i_clk), .i_we(i_cmd.we_free), .i_waddr(i_cmd.waddr[AW-1:0]),
        .i_wdata(i_cmd.free), .i_raddr(i_cmd.raddr[AW-1:0]), .o_rdata(rd_free)
    );

    ffca_ram #(.WIDTH(LW), .DEPTH(ARENA_MAX_UNITS)) u_units (
        .i_clk(i_clk), .i_we(i_cmd.we_units), .i_waddr(i_cmd.waddr[AW-1:0]),
        .i_wdata(i_cmd.units[LW-1:0]), .i_raddr(i_cmd.raddr[AW-1:0]), .o_rdata(rd_units)
    );

    ffca_ram #(.WIDTH(LW), .DEPTH(ARENA_MAX_UNITS)) u_next (
        .i_clk(i_clk), .i_we(i_cmd.we_next), .i_waddr(i_cmd.waddr[AW-1:0]),
        .i_wdata(i_cmd.next[LW-1:0]), .i_raddr(i_cmd.raddr[AW-1:0]), .o_rdata(rd_next)
    );

    ffca_ram #(.WIDTH(LW), .DEPTH(ARENA_MAX_UNITS)) u_prev (
        .i_clk(i_clk), .i_we(i_cmd.we_prev), .i_waddr(i_cmd.waddr[AW-1:0]),
        .i_wdata(i_cmd.prev[LW-1:0]), .i_raddr(i_cmd.raddr[AW-1:0]), .o_rdata(rd_prev)
    );

    always_comb begin
        o_rsp.free  = rd_free;
        o_rsp.units = MAX_LW'(rd_units);
        o_rsp.next  = MAX_LW'((rd_next >= NULL_LINK) ? NULL_LINK : rd_next);
        o_rsp.prev  = MAX_LW'((rd_prev >= NULL_LINK) ? NULL_LINK : rd_prev);
    end

endmodule

[hw/rtl/ffca_controller.sv]
// ----------------------------------------------------------------------------
// ffca_controller: allocator sequencer
// Decodes requests, keeps the bump pointer and list head, walks the free
// list and issues header reads and writes to the datapath.
// ----------------------------------------------------------------------------
module ffca_controller
    import ffca_pkg::*;
#(
    parameter int ARENA_MAX_UNITS = DEF_ARENA_MAX_UNITS,
    parameter int UNIT_BYTES      = DEF_UNIT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_req_command,
    input  logic [11:0] i_req_address,
    input  logic [15:0] i_req_byte_count,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [11:0] o_res_address,
    output logic [1:0]  o_res_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output t_mem_cmd    o_mem,
    input  t_mem_rsp    i_mem
);

    localparam int AW = $clog2(ARENA_MAX_UNITS);
    localparam int LW = AW + 1;
    localparam int W  = ((LW > 15) ? LW : 15) + 2;
    localparam logic [LW-1:0] NULL_LINK = LW'(ARENA_MAX_UNITS);
    localparam logic [W-1:0]  MAX_W     = W'(ARENA_MAX_UNITS);

    typedef enum logic [5:0] {
        S_IDLE, S_DEC, S_LIVE, S_ATOP, S_FTOP, S_G1, S_G2, S_DONE,
        S_AL0, S_AL_WALK, S_AL_CHK, S_AL_SPLIT, S_AL_SET,
        S_U_RD, S_U_R, S_U_W,
        S_L0, S_L1, S_L2, S_L3,
        S_F0, S_F1, S_F2, S_F3, S_FW, S_FW1, S_FB, S_FB1, S_FB2, S_FB4,
        S_FB5, S_FB6, S_FEND,
        S_SW, S_SW1, S_SD, S_SD1, S_SD2, S_SD3, S_SEND
    } t_state;

    t_state r_state, n_state, r_ret1, n_ret1, r_ret2, n_ret2;
    logic [11:0]   r_base, n_base;
    logic [12:0]   r_units, n_units;
    logic [LW-1:0] r_top, n_top, r_head, n_head;
    logic [1:0]    r_cmd, n_cmd;
    logic [11:0]   r_addr, n_addr;
    logic [W-1:0]  r_bl, n_bl;
    logic [LW-1:0] r_h, n_h, r_old, n_old, r_c, n_c, r_n, n_n, r_last, n_last;
    logic [LW-1:0] r_steps, n_steps, r_fh, n_fh, r_nb, n_nb;
    logic [W-1:0]  r_cl, n_cl, r_len, n_len;
    logic          r_aok, n_aok;
    logic [LW-1:0] r_ux, n_ux, r_up, n_up, r_un, n_un;
    logic [LW-1:0] r_lloc, n_lloc, r_ln, n_ln, r_lpx, n_lpx;
    logic [W-1:0]  r_lx, n_lx, r_llen, n_llen, r_t, n_t, r_tl, n_tl;
    logic [11:0]   r_res, n_res;
    logic [1:0]    r_stat, n_stat;
    logic          r_ovalid, n_ovalid;
    logic [11:0]   r_ores, n_ores;
    logic [1:0]    r_ostat, n_ostat;

    logic [W-1:0]  s_start, s_end, s_cfg_start, s_bytes, s_bl_in, s_h;
    logic [W-1:0]  rd_units;
    logic [LW-1:0] rd_next, rd_prev;

    assign s_start  = (W'(r_base) < MAX_W) ? W'(r_base) : MAX_W;
    assign s_end    = ((s_start + W'(r_units)) < MAX_W) ? (s_start + W'(r_units)) : MAX_W;
    assign s_cfg_start = (i_cfg_index == CFG_ARENA_BASE) ?
                         ((W'(i_cfg_data[11:0]) < MAX_W) ? W'(i_cfg_data[11:0]) : MAX_W) :
                         s_start;
    assign s_bytes  = (i_req_byte_count == 16'd0) ? W'(1) : W'(i_req_byte_count);
    assign s_bl_in  = ((s_bytes + W'(UNIT_BYTES - 1)) / W'(UNIT_BYTES)) + W'(1);
    assign s_h      = W'(r_addr) - W'(1);
    assign rd_units = W'(i_mem.units[LW-1:0]);
    assign rd_next  = i_mem.next[LW-1:0];
    assign rd_prev  = i_mem.prev[LW-1:0];

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_res_valid   = r_ovalid;
    assign o_res_address = r_ores;
    assign o_res_status  = r_ostat;

    always_comb begin
        n_state = r_state; n_ret1 = r_ret1; n_ret2 = r_ret2;
        n_base = r_base; n_units = r_units; n_top = r_top; n_head = r_head;
        n_cmd = r_cmd; n_addr = r_addr; n_bl = r_bl; n_h = r_h; n_old = r_old;
        n_c = r_c; n_n = r_n; n_last = r_last; n_steps = r_steps; n_fh = r_fh;
        n_nb = r_nb; n_cl = r_cl; n_len = r_len; n_aok = r_aok;
        n_ux = r_ux; n_up = r_up; n_un = r_un;
        n_lloc = r_lloc; n_ln = r_ln; n_lpx = r_lpx; n_lx = r_lx; n_llen = r_llen;
        n_t = r_t; n_tl = r_tl; n_res = r_res; n_stat = r_stat;
        n_ovalid = r_ovalid; n_ores = r_ores; n_ostat = r_ostat;
        o_mem = '0;
        o_mem.raddr = MAX_AW'(r_c);

        if (r_ovalid && i_res_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd   = i_req_command;
                    n_addr  = i_req_address;
                    n_bl    = s_bl_in;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res = 12'd0;
                if (r_cmd == CMD_ALLOC || (r_cmd == CMD_REALLOC && r_addr == 12'd0)) begin
                    n_ret1  = S_ATOP;
                    n_state = S_AL0;
                end else if ((r_cmd == CMD_FREE || r_cmd == CMD_REALLOC) && r_addr != 12'd0) begin
                    if (s_h < s_start || s_h >= W'(r_top) || s_h >= MAX_W) begin
                        n_stat  = ST_NONE;
                        n_state = S_DONE;
                    end else begin
                        n_h         = LW'(s_h);
                        o_mem.raddr = MAX_AW'(s_h);
                        n_state     = S_LIVE;
                    end
                end else begin
                    n_stat  = ST_NONE;
                    n_state = S_DONE;
                end
            end
            S_LIVE: begin
                if (i_mem.free || rd_units == W'(0) || rd_units > (W'(r_top) - W'(r_h))) begin
                    n_stat  = ST_NONE;
                    n_state = S_DONE;
                end else begin
                    n_old = LW'(rd_units);
                    if (r_cmd == CMD_FREE) begin
                        n_fh    = r_h;
                        n_ret1  = S_FTOP;
                        n_state = S_F0;
                    end else if (rd_units == r_bl) begin
                        n_res   = r_addr;
                        n_stat  = ST_DONE;
                        n_state = S_DONE;
                    end else if (rd_units > r_bl) begin
                        n_t     = W'(r_h) + r_bl;
                        n_tl    = rd_units - r_bl;
                        n_c     = r_head;
                        n_last  = NULL_LINK;
                        n_steps = '0;
                        n_state = S_SW;
                    end else begin
                        n_ret1  = S_G1;
                        n_state = S_AL0;
                    end
                end
            end
            S_ATOP: begin
                n_res   = r_aok ? (12'(r_nb) + 12'd1) : 12'd0;
                n_stat  = r_aok ? ST_DONE : ST_NO_SPACE;
                n_state = S_DONE;
            end
            S_FTOP: begin
                n_res   = 12'd0;
                n_stat  = ST_DONE;
                n_state = S_DONE;
            end
            S_G1: begin
                if (!r_aok) begin
                    n_res   = 12'd0;
                    n_stat  = ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    n_fh    = r_h;
                    n_ret1  = S_G2;
                    n_state = S_F0;
                end
            end
            S_G2: begin
                n_res   = 12'(r_nb) + 12'd1;
                n_stat  = ST_DONE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_res_ready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_ostat  = r_stat;
                    n_state  = S_IDLE;
                end
            end
            S_AL0: begin
                if (W'(r_top) >= s_start && (W'(r_top) + r_bl) <= s_end) begin
                    n_nb    = r_top;
                    n_top   = LW'(W'(r_top) + r_bl);
                    n_state = S_AL_SET;
                end else begin
                    n_c     = r_head;
                    n_steps = '0;
                    n_state = S_AL_WALK;
                end
            end
            S_AL_WALK: begin
                if (r_c == NULL_LINK || r_steps == NULL_LINK) begin
                    n_aok   = 1'b0;
                    n_state = r_ret1;
                end else begin
                    o_mem.raddr = MAX_AW'(r_c);
                    n_state     = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                if (rd_units >= r_bl) begin
                    n_nb    = r_c;
                    n_cl    = rd_units;
                    n_ux    = r_c;
                    n_ret2  = S_AL_SPLIT;
                    n_state = S_U_RD;
                end else begin
                    n_c     = rd_next;
                    n_steps = r_steps + LW'(1);
                    n_state = S_AL_WALK;
                end
            end
            S_AL_SPLIT: begin
                if (r_cl > r_bl) begin
                    n_lloc  = r_up;
                    n_lx    = W'(r_nb) + r_bl;
                    n_llen  = r_cl - r_bl;
                    n_ret2  = S_AL_SET;
                    n_state = S_L0;
                end else begin
                    n_state = S_AL_SET;
                end
            end
            S_AL_SET: begin
                o_mem.waddr    = MAX_AW'(r_nb);
                o_mem.we_free  = 1'b1;
                o_mem.free     = 1'b0;
                o_mem.we_units = 1'b1;
                o_mem.units    = MAX_LW'(LW'(r_bl));
                n_aok          = 1'b1;
                n_state        = r_ret1;
            end
            S_U_RD: begin
                o_mem.raddr = MAX_AW'(r_ux);
                n_state     = S_U_R;
            end
            S_U_R: begin
                n_up = rd_prev;
                n_un = rd_next;
                if (rd_prev != NULL_LINK) begin
                    o_mem.waddr   = MAX_AW'(rd_prev);
                    o_mem.we_next = 1'b1;
                    o_mem.next    = MAX_LW'(rd_next);
                end else begin
                    n_head = rd_next;
                end
                n_state = S_U_W;
            end
            S_U_W: begin
                if (r_un != NULL_LINK) begin
                    o_mem.waddr   = MAX_AW'(r_un);
                    o_mem.we_prev = 1'b1;
                    o_mem.prev    = MAX_LW'(r_up);
                end
                n_state = r_ret2;
            end
            S_L0: begin
                if (r_lx >= MAX_W) begin
                    n_state = r_ret2;
                end else if (r_lloc == NULL_LINK) begin
                    n_ln    = r_head;
                    n_head  = LW'(r_lx);
                    n_lpx   = NULL_LINK;
                    n_state = S_L2;
                end else begin
                    o_mem.raddr = MAX_AW'(r_lloc);
                    n_state     = S_L1;
                end
            end
            S_L1: begin
                n_ln          = rd_next;
                o_mem.waddr   = MAX_AW'(r_lloc);
                o_mem.we_next = 1'b1;
                o_mem.next    = MAX_LW'(r_lx);
                n_lpx         = r_lloc;
                n_state       = S_L2;
            end
            S_L2: begin
                o_mem.waddr    = MAX_AW'(r_lx);
                o_mem.we_prev  = 1'b1;
                o_mem.prev     = MAX_LW'(r_lpx);
                o_mem.we_next  = 1'b1;
                o_mem.next     = MAX_LW'(r_ln);
                o_mem.we_free  = 1'b1;
                o_mem.free     = 1'b1;
                o_mem.we_units = 1'b1;
                o_mem.units    = MAX_LW'(LW'(r_llen));
                n_state        = S_L3;
            end
            S_L3: begin
                if (r_ln != NULL_LINK) begin
                    o_mem.waddr   = MAX_AW'(r_ln);
                    o_mem.we_prev = 1'b1;
                    o_mem.prev    = MAX_LW'(r_lx);
                end
                n_state = r_ret2;
            end
            S_F0: begin
                o_mem.raddr = MAX_AW'(r_fh);
                n_state     = S_F1;
            end
            S_F1: begin
                n_len = rd_units;
                if (r_head == NULL_LINK) begin
                    n_lloc  = NULL_LINK;
                    n_lx    = W'(r_fh);
                    n_llen  = rd_units;
                    n_ret2  = S_FEND;
                    n_state = S_L0;
                end else if (r_head > r_fh) begin
                    if (W'(r_fh) + rd_units == W'(r_head)) begin
                        o_mem.raddr = MAX_AW'(r_head);
                        n_state     = S_F2;
                    end else begin
                        n_lloc  = NULL_LINK;
                        n_lx    = W'(r_fh);
                        n_llen  = rd_units;
                        n_ret2  = S_FEND;
                        n_state = S_L0;
                    end
                end else begin
                    n_c     = r_head;
                    n_steps = '0;
                    n_state = S_FW;
                end
            end
            S_F2: begin
                n_len   = r_len + rd_units;
                n_ux    = r_head;
                n_ret2  = S_F3;
                n_state = S_U_RD;
            end
            S_F3: begin
                n_lloc  = NULL_LINK;
                n_lx    = W'(r_fh);
                n_llen  = r_len;
                n_ret2  = S_FEND;
                n_state = S_L0;
            end
            S_FW: begin
                o_mem.raddr = MAX_AW'(r_c);
                n_state     = S_FW1;
            end
            S_FW1: begin
                if (rd_next == NULL_LINK || rd_next > r_fh) begin
                    n_state = S_FB;
                end else begin
                    n_c     = rd_next;
                    n_steps = r_steps + LW'(1);
                    n_state = ((r_steps + LW'(1)) == NULL_LINK) ? S_FB : S_FW;
                end
            end
            S_FB: begin
                o_mem.raddr = MAX_AW'(r_c);
                n_state     = S_FB1;
            end
            S_FB1: begin
                n_n = rd_next;
                if (W'(r_c) + rd_units == W'(r_fh)) begin
                    n_cl           = rd_units + r_len;
                    o_mem.waddr    = MAX_AW'(r_c);
                    o_mem.we_units = 1'b1;
                    o_mem.units    = MAX_LW'(LW'(rd_units + r_len));
                    n_state        = S_FB2;
                end else if (rd_next != NULL_LINK && W'(r_fh) + r_len == W'(rd_next)) begin
                    o_mem.raddr = MAX_AW'(rd_next);
                    n_state     = S_FB5;
                end else begin
                    n_lloc  = r_c;
                    n_lx    = W'(r_fh);
                    n_llen  = r_len;
                    n_ret2  = S_FEND;
                    n_state = S_L0;
                end
            end
            S_FB2: begin
                o_mem.waddr   = MAX_AW'(r_fh);
                o_mem.we_free = 1'b1;
                o_mem.free    = 1'b1;
                if (r_n != NULL_LINK && W'(r_c) + r_cl == W'(r_n)) begin
                    o_mem.raddr = MAX_AW'(r_n);
                    n_state     = S_FB4;
                end else begin
                    n_state = S_FEND;
                end
            end
            S_FB4: begin
                o_mem.waddr    = MAX_AW'(r_c);
                o_mem.we_units = 1'b1;
                o_mem.units    = MAX_LW'(LW'(r_cl + rd_units));
                n_ux           = r_n;
                n_ret2         = S_FEND;
                n_state        = S_U_RD;
            end
            S_FB5: begin
                n_len   = r_len + rd_units;
                n_ux    = r_n;
                n_ret2  = S_FB6;
                n_state = S_U_RD;
            end
            S_FB6: begin
                n_lloc  = r_c;
                n_lx    = W'(r_fh);
                n_llen  = r_len;
                n_ret2  = S_FEND;
                n_state = S_L0;
            end
            S_FEND: begin
                n_state = r_ret1;
            end
            S_SW: begin
                if (r_c == NULL_LINK) begin
                    n_state = S_SD;
                end else if (r_steps == NULL_LINK) begin
                    n_c     = NULL_LINK;
                    n_state = S_SD;
                end else begin
                    o_mem.raddr = MAX_AW'(r_c);
                    n_state     = S_SW1;
                end
            end
            S_SW1: begin
                if (r_c > r_h) begin
                    n_state = S_SD;
                end else begin
                    n_last  = r_c;
                    n_c     = rd_next;
                    n_steps = r_steps + LW'(1);
                    n_state = S_SW;
                end
            end
            S_SD: begin
                if (r_c == NULL_LINK) begin
                    n_lloc  = r_last;
                    n_lx    = r_t;
                    n_llen  = r_tl;
                    n_ret2  = S_SEND;
                    n_state = S_L0;
                end else begin
                    o_mem.raddr = MAX_AW'(r_c);
                    n_state = (W'(r_c) == W'(r_h) + W'(r_old)) ? S_SD1 : S_SD3;
                end
            end
            S_SD1: begin
                n_tl    = r_tl + rd_units;
                n_ux    = r_c;
                n_ret2  = S_SD2;
                n_state = S_U_RD;
            end
            S_SD2: begin
                n_lloc  = r_up;
                n_lx    = r_t;
                n_llen  = r_tl;
                n_ret2  = S_SEND;
                n_state = S_L0;
            end
            S_SD3: begin
                n_lloc  = rd_prev;
                n_lx    = r_t;
                n_llen  = r_tl;
                n_ret2  = S_SEND;
                n_state = S_L0;
            end
            S_SEND: begin
                o_mem.waddr    = MAX_AW'(r_h);
                o_mem.we_units = 1'b1;
                o_mem.units    = MAX_LW'(LW'(r_bl));
                n_res          = r_addr;
                n_stat         = ST_DONE;
                n_state        = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ARENA_BASE) begin
                n_base = i_cfg_data[11:0];
            end else begin
                n_units = i_cfg_data;
            end
            n_top  = LW'(s_cfg_start);
            n_head = NULL_LINK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret1   <= S_IDLE;
            r_ret2   <= S_IDLE;
            r_base   <= 12'd0;
            r_units  <= 13'd4096;
            r_top    <= '0;
            r_head   <= NULL_LINK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret1   <= n_ret1;
            r_ret2   <= n_ret2;
            r_base   <= n_base;
            r_units  <= n_units;
            r_top    <= n_top;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
        r_cmd <= n_cmd; r_addr <= n_addr; r_bl <= n_bl; r_h <= n_h; r_old <= n_old;
        r_c <= n_c; r_n <= n_n; r_last <= n_last; r_steps <= n_steps; r_fh <= n_fh;
        r_nb <= n_nb; r_cl <= n_cl; r_len <= n_len; r_aok <= n_aok;
        r_ux <= n_ux; r_up <= n_up; r_un <= n_un;
        r_lloc <= n_lloc; r_ln <= n_ln; r_lpx <= n_lpx; r_lx <= n_lx; r_llen <= n_llen;
        r_t <= n_t; r_tl <= n_tl; r_res <= n_res; r_stat <= n_stat;
        r_ores <= n_ores; r_ostat <= n_ostat;
    end

endmodule

[hw/rtl/first_fit_coalescing_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator: first-fit arena allocator with coalescing
// Top level joining the request sequencer and the block header store.
// ----------------------------------------------------------------------------
// One request is served at a time. A request that uses the free list
// walks it block by block, and a growing reallocation adds decoding and
// header updates; every step goes through the single read port of the
// header memory. A new request is taken while the previous result still
// waits at the output. Writing either configuration register empties the
// arena.
module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int ARENA_MAX_UNITS = DEF_ARENA_MAX_UNITS,
    parameter int UNIT_BYTES      = DEF_UNIT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // command[1:0], address[13:2], byte_count[29:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_address[11:0], status[13:12]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    t_mem_cmd    mem_cmd;
    t_mem_rsp    mem_rsp;
    logic [11:0] res_address;
    logic [1:0]  res_status;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {2'b00, res_status, res_address};

    ffca_controller #(
        .ARENA_MAX_UNITS(ARENA_MAX_UNITS),
        .UNIT_BYTES     (UNIT_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .o_req_ready     (s_axis_tready),
        .i_req_command   (s_axis_tdata[1:0]),
        .i_req_address   (s_axis_tdata[13:2]),
        .i_req_byte_count(s_axis_tdata[29:14]),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_res_address   (res_address),
        .o_res_status    (res_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_mem           (mem_cmd),
        .i_mem           (mem_rsp)
    );

    ffca_datapath #(
        .ARENA_MAX_UNITS(ARENA_MAX_UNITS)
    ) u_dp (
        .i_clk(i_clk),
        .i_cmd(mem_cmd),
        .o_rsp(mem_rsp)
    );

endmodule

[verif/tb_first_fit_coalescing_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_coalescing_allocator: self-checking bench of the allocator
// Drives allocate, free and reallocate requests over several arena settings.
// It tracks live blocks so that frees and reallocations mostly hit real
// blocks, and a scoreboard predicts every response and compares it.
// ----------------------------------------------------------------------------
module tb_first_fit_coalescing_allocator;
    import ffca_pkg::*;

    localparam int MAXU       = 4096;
    localparam int UNITB      = 16;
    localparam int NULL_LINK  = MAXU;
    localparam int WATCHDOG   = 60000;

    typedef struct {
        logic [11:0] address;
        logic [1:0]  status;
    } t_alloc_resp;

    class t_scoreboard;
        bit          hdr_free [MAXU];
        int unsigned hdr_units[MAXU];
        int unsigned nxt      [MAXU];
        int unsigned prv      [MAXU];
        int unsigned top;
        int unsigned head;
        int unsigned base;
        int unsigned units;
        t_alloc_resp pending[$];
        int          errors;

        function new();
            base   = 0;
            units  = 4096;
            top    = 0;
            head   = NULL_LINK;
            errors = 0;
        endfunction

        function int unsigned lk(int unsigned v);
            return (v < MAXU) ? v : NULL_LINK;
        endfunction

        function int unsigned start_u();
            return (base < MAXU) ? base : MAXU;
        endfunction

        function int unsigned end_u();
            int unsigned e;
            e = start_u() + units;
            return (e < MAXU) ? e : MAXU;
        endfunction

        function int unsigned units_for(int unsigned bytes);
            int unsigned b;
            b = (bytes != 0) ? bytes : 1;
            return (b + UNITB - 1) / UNITB + 1;
        endfunction

        function void configure(bit idx, int unsigned val);
            if (idx == CFG_ARENA_BASE) base = val & 12'hFFF;
            else units = val & 13'h1FFF;
            top  = start_u();
            head = NULL_LINK;
        endfunction

        function int unsigned unlink_blk(int unsigned x);
            int unsigned p, n;
            p = lk((x < MAXU) ? prv[x] : NULL_LINK);
            n = lk((x < MAXU) ? nxt[x] : NULL_LINK);
            if (p != NULL_LINK) nxt[p] = n;
            else head = n;
            if (n != NULL_LINK) prv[n] = p;
            return p;
        endfunction

        function void link_after(int unsigned loc, int unsigned x, int unsigned len);
            int unsigned n;
            if (x >= MAXU) return;
            if (loc == NULL_LINK) begin
                n = lk(head);
                head = x;
                prv[x] = NULL_LINK;
            end else begin
                n = lk((loc < MAXU) ? nxt[loc] : NULL_LINK);
                if (loc < MAXU) nxt[loc] = x;
                prv[x] = loc;
            end
            nxt[x] = n;
            if (n != NULL_LINK) prv[n] = x;
            hdr_free[x]  = 1;
            hdr_units[x] = len;
        endfunction

        function int unsigned take(int unsigned bytes);
            int unsigned bl, h, c, p, cl, steps;
            bl = units_for(bytes);
            if (top >= start_u() && top + bl <= end_u()) begin
                h = top;
                top = h + bl;
            end else begin
                c = lk(head);
                for (steps = 0; c != NULL_LINK && steps < MAXU; steps++) begin
                    if (hdr_units[c] >= bl) break;
                    c = lk(nxt[c]);
                end
                if (c == NULL_LINK || steps >= MAXU) return NULL_LINK;
                h  = c;
                cl = hdr_units[c];
                p  = unlink_blk(c);
                if (cl > bl) link_after(p, c + bl, cl - bl);
            end
            if (h >= MAXU) return NULL_LINK;
            hdr_free[h]  = 0;
            hdr_units[h] = bl;
            return h;
        endfunction

        function void give_back(int unsigned h);
            int unsigned len, hd, c, n, steps;
            len = hdr_units[h];
            hd  = lk(head);
            if (hd == NULL_LINK) begin
                link_after(NULL_LINK, h, len);
                return;
            end
            if (hd > h) begin
                if (h + len == hd) begin
                    len += hdr_units[hd];
                    void'(unlink_blk(hd));
                end
                link_after(NULL_LINK, h, len);
                return;
            end
            c = hd;
            for (steps = 0; steps < MAXU; steps++) begin
                n = lk(nxt[c]);
                if (n == NULL_LINK || n > h) break;
                c = n;
            end
            n = lk(nxt[c]);
            if (c + hdr_units[c] == h) begin
                hdr_units[c] += len;
                hdr_free[h] = 1;
                if (n != NULL_LINK && c + hdr_units[c] == n) begin
                    hdr_units[c] += hdr_units[n];
                    void'(unlink_blk(n));
                end
            end else begin
                if (n != NULL_LINK && h + len == n) begin
                    len += hdr_units[n];
                    void'(unlink_blk(n));
                end
                link_after(c, h, len);
            end
        endfunction

        function bit live(int unsigned h);
            int unsigned u;
            if (h < start_u() || h >= top || h >= MAXU) return 0;
            u = hdr_units[h];
            return !hdr_free[h] && u >= 1 && u <= top - h;
        endfunction

        function void shrink(int unsigned h, int unsigned bl);
            int unsigned old, t, tl, c, last, steps;
            old  = hdr_units[h];
            t    = h + bl;
            tl   = old - bl;
            c    = lk(head);
            last = NULL_LINK;
            for (steps = 0; c != NULL_LINK && steps < MAXU; steps++) begin
                if (c > h) break;
                last = c;
                c = lk(nxt[c]);
            end
            if (steps >= MAXU) c = NULL_LINK;
            if (c == NULL_LINK) begin
                link_after(last, t, tl);
            end else if (c == h + old) begin
                tl += hdr_units[c];
                link_after(unlink_blk(c), t, tl);
            end else begin
                link_after(lk(prv[c]), t, tl);
            end
            hdr_units[h] = bl;
        endfunction

        function t_alloc_resp note_request(logic [1:0] cmd, logic [11:0] addr,
                                           logic [15:0] bytes);
            t_alloc_resp r;
            int unsigned h, nb, bl;
            r.address = 12'd0;
            r.status  = ST_NONE;
            if (cmd == CMD_ALLOC || (cmd == CMD_REALLOC && addr == 0)) begin
                nb = take(bytes);
                if (nb == NULL_LINK) r.status = ST_NO_SPACE;
                else begin
                    r.address = 12'(nb + 1);
                    r.status  = ST_DONE;
                end
            end else if ((cmd == CMD_FREE || cmd == CMD_REALLOC) && addr != 0) begin
                h = addr - 1;
                if (live(h)) begin
                    if (cmd == CMD_FREE) begin
                        give_back(h);
                        r.status = ST_DONE;
                    end else begin
                        bl = units_for(bytes);
                        if (hdr_units[h] == bl) begin
                            r.address = addr;
                            r.status  = ST_DONE;
                        end else if (hdr_units[h] > bl) begin
                            shrink(h, bl);
                            r.address = addr;
                            r.status  = ST_DONE;
                        end else begin
                            nb = take(bytes);
                            if (nb == NULL_LINK) r.status = ST_NO_SPACE;
                            else begin
                                give_back(h);
                                r.address = 12'(nb + 1);
                                r.status  = ST_DONE;
                            end
                        end
                    end
                end
            end
            pending.push_back(r);
            return r;
        endfunction

        function void check_response(logic [11:0] addr, logic [1:0] status);
            t_alloc_resp e;
            if (pending.size() == 0) begin
                $error("unexpected response address=%0d status=%0d", addr, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (addr !== e.address) begin
                $error("result_address expected %0d actual %0d", e.address, addr);
                errors++;
            end
            if (status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 0;
    logic [12:0] i_cfg_data = '0;

    first_fit_coalescing_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_scoreboard sb = new();
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [11:0] live_q[$];
    logic [11:0] stale_q[$];

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_response(m_axis_tdata[11:0], m_axis_tdata[13:12]);
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic drop_live(logic [11:0] a);
        foreach (live_q[i]) begin
            if (live_q[i] == a) begin
                live_q.delete(i);
                break;
            end
        end
    endtask

    task automatic send_request(logic [1:0] cmd, logic [11:0] addr, logic [15:0] bytes);
        t_alloc_resp r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, bytes, addr, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        r = sb.note_request(cmd, addr, bytes);
        if (r.status == ST_DONE) begin
            if (cmd == CMD_FREE) begin
                drop_live(addr);
                stale_q.push_back(addr);
            end else if (r.address != addr) begin
                if (addr != 0) begin
                    drop_live(addr);
                    stale_q.push_back(addr);
                end
                live_q.push_back(r.address);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(bit idx, logic [12:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.configure(idx, val);
        live_q.delete();
        stale_q.delete();
    endtask

    function automatic logic [15:0] pick_bytes();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 16'($urandom_range(200));
        if (k < 95) return 16'($urandom_range(1500));
        return 16'($urandom);
    endfunction

    function automatic logic [11:0] pick_live();
        if (live_q.size() == 0) return 12'd0;
        return live_q[$urandom_range(live_q.size() - 1)];
    endfunction

    task automatic random_requests(int n);
        int k;
        logic [11:0] a;
        repeat (n) begin
            k = $urandom_range(99);
            if (k < 45) send_request(CMD_ALLOC, 12'd0, pick_bytes());
            else if (k < 78) send_request(CMD_FREE, pick_live(), 16'd0);
            else if (k < 90) send_request(CMD_REALLOC, pick_live(), pick_bytes());
            else if (k < 93) send_request(CMD_REALLOC, 12'd0, pick_bytes());
            else if (k < 95) send_request(2'd3, 12'($urandom), 16'($urandom));
            else if (k < 97) begin
                a = (stale_q.size() != 0) ? stale_q[$urandom_range(stale_q.size() - 1)] : 12'd0;
                send_request($urandom_range(1) ? CMD_FREE : CMD_REALLOC, a, pick_bytes());
            end else begin
                a = (sb.top + 1 < 4095) ? 12'($urandom_range(4095, sb.top + 1)) : 12'hFFF;
                send_request($urandom_range(1) ? CMD_FREE : CMD_REALLOC, a, 16'($urandom));
            end
        end
    endtask

    initial begin
        logic [11:0] a, b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_ALLOC, 12'd0, 16'd0);
        send_request(CMD_ALLOC, 12'd0, 16'd1);
        send_request(CMD_ALLOC, 12'd0, 16'd16);
        send_request(CMD_ALLOC, 12'd0, 16'd17);
        send_request(CMD_ALLOC, 12'd0, 16'hFFFF);
        send_request(CMD_FREE, 12'd0, 16'd0);
        send_request(2'd3, 12'hFFF, 16'hFFFF);
        send_request(CMD_FREE, 12'hFFF, 16'd0);
        a = live_q[1];
        b = live_q[2];
        send_request(CMD_FREE, a, 16'd0);
        send_request(CMD_FREE, a, 16'd0);
        send_request(CMD_REALLOC, 12'd0, 16'd40);
        send_request(CMD_REALLOC, b, 16'd17);
        send_request(CMD_REALLOC, b, 16'd3);
        send_request(CMD_REALLOC, b, 16'd300);
        send_request(CMD_FREE, live_q[0], 16'd0);
        send_request(CMD_ALLOC, 12'd0, 16'd100);
        send_request(CMD_FREE, live_q[0], 16'd0);

        write_reg(CFG_ARENA_BASE, 13'd100);
        write_reg(CFG_ARENA_UNITS, 13'd64);
        send_idle = 28;
        recv_idle = 66;
        hold_request = 400;
        random_requests(250);

        write_reg(CFG_ARENA_UNITS, 13'd300);
        send_idle = 66;
        recv_idle = 28;
        random_requests(200);

        write_reg(CFG_ARENA_BASE, 13'd4095);
        write_reg(CFG_ARENA_UNITS, 13'd2);
        send_request(CMD_ALLOC, 12'd0, 16'd0);
        send_request(CMD_REALLOC, 12'd0, 16'd1);
        send_request(CMD_FREE, 12'hFFF, 16'd0);

        write_reg(CFG_ARENA_BASE, 13'd0);
        write_reg(CFG_ARENA_UNITS, 13'd4096);
        send_idle = 0;
        recv_idle = 0;
        random_requests(180);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
